FILE: sv/ptc_pkg.sv
// Shared types, register codes and arithmetic helpers of the pressure and
// temperature compensation pipeline. No dependencies.
package ptc_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned UpW     = 24;
  localparam int unsigned TempW   = 16;
  localparam int unsigned PressW  = 18;

  typedef enum logic [2:0] {
    RegAc1Ac2 = 3'd0,
    RegAc3Ac4 = 3'd1,
    RegAc5Ac6 = 3'd2,
    RegB1B2   = 3'd3,
    RegMcMd   = 3'd4,
    RegOss    = 3'd5
  } ptc_reg_e;

  localparam logic [1:0]  OssReset   = 2'd1;
  localparam logic [31:0] Offset4000 = 32'd4000;
  localparam logic [31:0] Half32768  = 32'd32768;
  localparam logic [16:0] Scale50000 = 17'd50000;
  localparam logic [31:0] K3038      = 32'd3038;
  localparam logic [31:0] KNeg7357   = -32'sd7357;
  localparam logic [31:0] K3791      = 32'd3791;
  localparam logic [31:0] TempMax    = 32'sd32767;
  localparam logic [31:0] TempMin    = -32'sd32768;
  localparam logic [31:0] PressMax   = 32'd262143;
  localparam logic [31:0] BigB7      = 32'h8000_0000;

  // Sideband carried through the temperature divider
  typedef struct packed {
    logic [DataW-1:0] x1;
    logic             neg;
    logic             dz;
    logic [UpW-1:0]   up;
  } ptc_side1_t;

  // Sideband carried through the pressure divider
  typedef struct packed {
    logic [TempW-1:0] temp;
    logic             tz;
    logic             b4z;
    logic             big;
  } ptc_side2_t;

  // Low word of a product; same bits for signed and unsigned operands
  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  // Signed division by 2**k, truncating toward zero
  function automatic logic [31:0] sdiv_p2(input logic [31:0] a, input int unsigned k);
    logic [31:0] bias;
    logic [31:0] sum;
    bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    sum  = a + bias;
    return $unsigned($signed(sum) >>> k);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] zext16(input logic [15:0] v);
    return {16'd0, v};
  endfunction

endpackage

FILE: sv/ptc_div.sv
// Pipelined restoring divider for unsigned 32-bit operands, one quotient bit
// per stage, with a sideband word carried alongside. Uses ptc_pkg.
module ptc_div #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [ptc_pkg::DataW-1:0] dividend_i,
  input  logic [ptc_pkg::DataW-1:0] divisor_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic [ptc_pkg::DataW-1:0] quotient_o,
  output logic [SIDE_W-1:0]        side_o
);

  localparam int unsigned DW  = ptc_pkg::DataW;
  localparam int unsigned NST = ptc_pkg::DataW;

  logic [NST-1:0] vld_q;
  logic [DW-1:0]     rem_q  [NST];
  logic [DW-1:0]     quo_q  [NST];
  logic [DW-1:0]     den_q  [NST];
  logic [SIDE_W-1:0] side_q [NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic [DW-1:0]     r_in;
    logic [DW-1:0]     q_in;
    logic [DW-1:0]     d_in;
    logic [SIDE_W-1:0] s_in;
    logic [DW:0]       sh;
    logic [DW:0]       df;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = dividend_i;
      assign d_in = divisor_i;
      assign s_in = side_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign q_in = quo_q[k-1];
      assign d_in = den_q[k-1];
      assign s_in = side_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign sh = {r_in, q_in[DW-1]};
    assign df = sh - {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= df[DW] ? sh[DW-1:0] : df[DW-1:0];
        quo_q[k]  <= {q_in[DW-2:0], ~df[DW]};
        den_q[k]  <= d_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o    = vld_q[NST-1];
  assign quotient_o = quo_q[NST-1];
  assign side_o     = side_q[NST-1];

endmodule

FILE: sv/pressure_temp_compensation.sv
// Top level of the pressure and temperature compensation pipeline with its
// APB register file. Uses ptc_pkg and ptc_div.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o    raw_temp_i, raw_press_i
//   result    out        out_valid_o / out_stall_i  temp_tenths_o, press_pa_o, div_error_o
//   config    in         psel, penable, pwrite      paddr, pwdata, prdata
//
// One transaction per cycle while the result is not stalled; 14 arithmetic stages plus
// two 32-stage dividers, one quotient bit per stage.
// The whole pipeline advances together; it holds while the output register
// carries a result that the receiver stalls, and bubbles move on otherwise.
// Reset clears the valid bits and loads the registers with their reset values.
module pressure_temp_compensation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 raw_temp_i,
  input  logic [23:0]                 raw_press_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [15:0]          temp_tenths_o,
  output logic [17:0]                 press_pa_o,
  output logic                        div_error_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptc_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned S1W = $bits(ptc_pkg::ptc_side1_t);
  localparam int unsigned S2W = $bits(ptc_pkg::ptc_side2_t);

  // ---------------- registers ----------------
  logic [31:0] c0_q, c1_q, c2_q, c3_q, c4_q;
  logic [1:0]  oss_q;
  ptc_pkg::ptc_reg_e ridx;

  assign ridx   = ptc_pkg::ptc_reg_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q  <= '0;
      c1_q  <= '0;
      c2_q  <= '0;
      c3_q  <= '0;
      c4_q  <= '0;
      oss_q <= ptc_pkg::OssReset;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        ptc_pkg::RegAc1Ac2: c0_q  <= pwdata;
        ptc_pkg::RegAc3Ac4: c1_q  <= pwdata;
        ptc_pkg::RegAc5Ac6: c2_q  <= pwdata;
        ptc_pkg::RegB1B2:   c3_q  <= pwdata;
        ptc_pkg::RegMcMd:   c4_q  <= pwdata;
        ptc_pkg::RegOss:    oss_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      ptc_pkg::RegAc1Ac2: prdata = c0_q;
      ptc_pkg::RegAc3Ac4: prdata = c1_q;
      ptc_pkg::RegAc5Ac6: prdata = c2_q;
      ptc_pkg::RegB1B2:   prdata = c3_q;
      ptc_pkg::RegMcMd:   prdata = c4_q;
      ptc_pkg::RegOss:    prdata = {30'd0, oss_q};
      default:            prdata = '0;
    endcase
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = ptc_pkg::sext16(c0_q[31:16]);
  assign ac2 = ptc_pkg::sext16(c0_q[15:0]);
  assign ac3 = ptc_pkg::sext16(c1_q[31:16]);
  assign ac4 = ptc_pkg::zext16(c1_q[15:0]);
  assign ac5 = ptc_pkg::zext16(c2_q[31:16]);
  assign ac6 = ptc_pkg::zext16(c2_q[15:0]);
  assign b1  = ptc_pkg::sext16(c3_q[31:16]);
  assign b2  = ptc_pkg::sext16(c3_q[15:0]);
  assign mc  = ptc_pkg::sext16(c4_q[31:16]);
  assign md  = ptc_pkg::sext16(c4_q[15:0]);

  // ---------------- pipeline control ----------------
  logic en;
  logic out_vld_q;
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------- stage 1: UT product, UP ----------------
  logic        v1_q;
  logic [31:0] m1_q;
  logic [23:0] up1_q;
  logic [3:0]  psh;
  assign psh = 4'd8 - {2'd0, oss_q};

  // ---------------- stage 2: X1 and temperature divisor ----------------
  logic        v2_q;
  logic [31:0] x1t2_q, dvt2_q;
  logic [23:0] up2_q;
  logic [31:0] x1t_d;
  assign x1t_d = ptc_pkg::sdiv_p2(m1_q, 15);

  // ---------------- stage 3: magnitudes into the divider ----------------
  logic        v3_q;
  logic [31:0] num3_q, den3_q;
  ptc_pkg::ptc_side1_t sd3_q;
  logic [31:0] mcnum;
  assign mcnum = mc << 11;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q   <= ptc_pkg::mul_lo({16'd0, raw_temp_i} - ac6, ac5);
      up1_q  <= raw_press_i >> psh;
      x1t2_q <= x1t_d;
      dvt2_q <= x1t_d + md;
      up2_q  <= up1_q;
      num3_q <= mcnum[31] ? (32'd0 - mcnum) : mcnum;
      den3_q <= dvt2_q[31] ? (32'd0 - dvt2_q) : dvt2_q;
      sd3_q.x1  <= x1t2_q;
      sd3_q.neg <= mcnum[31] ^ dvt2_q[31];
      sd3_q.dz  <= (dvt2_q == '0);
      sd3_q.up  <= up2_q;
    end
  end

  logic                v4i;
  logic [31:0]         q1;
  logic [S1W-1:0]      sd4_raw;
  ptc_pkg::ptc_side1_t sd4;

  ptc_div #(.SIDE_W(S1W)) u_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v3_q),
    .dividend_i (num3_q),
    .divisor_i  (den3_q),
    .side_i     (sd3_q),
    .valid_o    (v4i),
    .quotient_o (q1),
    .side_o     (sd4_raw)
  );
  assign sd4 = ptc_pkg::ptc_side1_t'(sd4_raw);

  // ---------------- stage 4: B5, T, B6 ----------------
  logic [31:0] x2t, b5, tq;
  assign x2t = sd4.dz ? 32'd0 : (sd4.neg ? (32'd0 - q1) : q1);
  assign b5  = sd4.x1 + x2t;
  assign tq  = ptc_pkg::sdiv_p2(b5 + 32'd8, 4);

  logic        v4_q, tz4_q;
  logic [15:0] t4_q;
  logic [31:0] b64_q;
  logic [23:0] up4_q;

  // ---------------- stage 5: products of B6 ----------------
  logic        v5_q, tz5_q;
  logic [15:0] t5_q;
  logic [31:0] msq5_q, mac25_q, mac35_q;
  logic [23:0] up5_q;

  // ---------------- stage 6: scaled products ----------------
  logic        v6_q, tz6_q;
  logic [15:0] t6_q;
  logic [31:0] sq6_q, x1a6_q, x1c6_q;
  logic [23:0] up6_q;

  // ---------------- stage 7: B2 and B1 products ----------------
  logic        v7_q, tz7_q;
  logic [15:0] t7_q;
  logic [31:0] mb27_q, mb17_q, x1a7_q, x1c7_q;
  logic [23:0] up7_q;

  // ---------------- stage 8: X3 terms ----------------
  logic        v8_q, tz8_q;
  logic [15:0] t8_q;
  logic [31:0] x38_q, x2p8_q, x1c8_q;
  logic [23:0] up8_q;

  // ---------------- stage 9: B3 and pressure X3 ----------------
  logic        v9_q, tz9_q;
  logic [15:0] t9_q;
  logic [31:0] b39_q, x3p9_q;
  logic [23:0] up9_q;
  logic [31:0] b3raw;
  assign b3raw = ((ac1 << 2) + x38_q) << oss_q;

  // ---------------- stage 10: B4 and B7 products ----------------
  logic        v10_q, tz10_q;
  logic [15:0] t10_q;
  logic [31:0] b4p10_q, b710_q;
  logic [16:0] scl;
  assign scl = ptc_pkg::Scale50000 >> oss_q;

  // ---------------- stage 11: pressure divider operands ----------------
  logic        v11_q;
  logic [31:0] num11_q, den11_q;
  ptc_pkg::ptc_side2_t sd11_q;
  logic [31:0] b4;
  assign b4 = {15'd0, b4p10_q[31:15]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else if (en) begin
      v4_q  <= v4i;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 4
      if ($signed(tq) > $signed(ptc_pkg::TempMax)) begin
        t4_q <= 16'sh7fff;
      end else if ($signed(tq) < $signed(ptc_pkg::TempMin)) begin
        t4_q <= 16'sh8000;
      end else begin
        t4_q <= tq[15:0];
      end
      tz4_q  <= sd4.dz;
      b64_q  <= b5 - ptc_pkg::Offset4000;
      up4_q  <= sd4.up;
      // stage 5
      t5_q    <= t4_q;
      tz5_q   <= tz4_q;
      up5_q   <= up4_q;
      msq5_q  <= ptc_pkg::mul_lo(b64_q, b64_q);
      mac25_q <= ptc_pkg::mul_lo(ac2, b64_q);
      mac35_q <= ptc_pkg::mul_lo(ac3, b64_q);
      // stage 6
      t6_q   <= t5_q;
      tz6_q  <= tz5_q;
      up6_q  <= up5_q;
      sq6_q  <= ptc_pkg::sdiv_p2(msq5_q, 12);
      x1a6_q <= ptc_pkg::sdiv_p2(mac25_q, 11);
      x1c6_q <= ptc_pkg::sdiv_p2(mac35_q, 13);
      // stage 7
      t7_q   <= t6_q;
      tz7_q  <= tz6_q;
      up7_q  <= up6_q;
      mb27_q <= ptc_pkg::mul_lo(b2, sq6_q);
      mb17_q <= ptc_pkg::mul_lo(b1, sq6_q);
      x1a7_q <= x1a6_q;
      x1c7_q <= x1c6_q;
      // stage 8
      t8_q   <= t7_q;
      tz8_q  <= tz7_q;
      up8_q  <= up7_q;
      x38_q  <= ptc_pkg::sdiv_p2(mb27_q, 11) + x1a7_q;
      x2p8_q <= ptc_pkg::sdiv_p2(mb17_q, 16);
      x1c8_q <= x1c7_q;
      // stage 9
      t9_q   <= t8_q;
      tz9_q  <= tz8_q;
      up9_q  <= up8_q;
      b39_q  <= ptc_pkg::sdiv_p2(b3raw + 32'd2, 2);
      x3p9_q <= ptc_pkg::sdiv_p2(x1c8_q + x2p8_q + 32'd2, 2);
      // stage 10
      t10_q   <= t9_q;
      tz10_q  <= tz9_q;
      b4p10_q <= ptc_pkg::mul_lo(ac4, x3p9_q + ptc_pkg::Half32768);
      b710_q  <= ptc_pkg::mul_lo({8'd0, up9_q} - b39_q, {15'd0, scl});
      // stage 11: a large B7 is divided first and doubled after
      num11_q     <= (b710_q >= ptc_pkg::BigB7) ? b710_q : (b710_q << 1);
      den11_q     <= b4;
      sd11_q.temp <= t10_q;
      sd11_q.tz   <= tz10_q;
      sd11_q.b4z  <= (b4 == '0);
      sd11_q.big  <= (b710_q >= ptc_pkg::BigB7);
    end
  end

  logic                v12i;
  logic [31:0]         q2;
  logic [S2W-1:0]      sd12_raw;
  ptc_pkg::ptc_side2_t sd12;

  ptc_div #(.SIDE_W(S2W)) u_div_p (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v11_q),
    .dividend_i (num11_q),
    .divisor_i  (den11_q),
    .side_i     (sd11_q),
    .valid_o    (v12i),
    .quotient_o (q2),
    .side_o     (sd12_raw)
  );
  assign sd12 = ptc_pkg::ptc_side2_t'(sd12_raw);

  // ---------------- stage 12: pressure correction products ----------------
  logic [31:0] p12, pd12;
  assign p12  = sd12.big ? (q2 << 1) : q2;
  assign pd12 = ptc_pkg::sdiv_p2(p12, 8);

  logic                v12_q;
  ptc_pkg::ptc_side2_t sd12_q;
  logic [31:0]         p12_q, msq12_q, m7357_12_q;

  // ---------------- stage 13 ----------------
  logic                v13_q;
  ptc_pkg::ptc_side2_t sd13_q;
  logic [31:0]         p13_q, m3038_13_q, x213_q;

  // ---------------- stage 14: output register ----------------
  logic [31:0] x1f, pf;
  assign x1f = ptc_pkg::sdiv_p2(m3038_13_q, 16);
  assign pf  = p13_q + ptc_pkg::sdiv_p2(x1f + x213_q + ptc_pkg::K3791, 4);

  logic        b4z_q;
  logic [15:0] temp_q;
  logic [17:0] press_q;
  logic        err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v12_q     <= 1'b0;
      v13_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v12_q     <= v12i;
      v13_q     <= v12_q;
      out_vld_q <= v13_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd12_q     <= sd12;
      p12_q      <= p12;
      msq12_q    <= ptc_pkg::mul_lo(pd12, pd12);
      m7357_12_q <= ptc_pkg::mul_lo(ptc_pkg::KNeg7357, p12);
      sd13_q     <= sd12_q;
      p13_q      <= p12_q;
      m3038_13_q <= ptc_pkg::mul_lo(msq12_q, ptc_pkg::K3038);
      x213_q     <= ptc_pkg::sdiv_p2(m7357_12_q, 16);
      temp_q     <= sd13_q.temp;
      err_q      <= sd13_q.tz | sd13_q.b4z;
      b4z_q      <= sd13_q.b4z;
      if (sd13_q.b4z || pf[31]) begin
        press_q <= '0;
      end else if (pf > ptc_pkg::PressMax) begin
        press_q <= '1;
      end else begin
        press_q <= pf[17:0];
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign temp_tenths_o = temp_q;
  assign press_pa_o    = press_q;
  assign div_error_o   = err_q;

`ifndef NO_ASSERTIONS
  // the pipeline only holds for a stalled result in the output register
  a_hold_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> out_vld_q) else $error("pipeline held without a stalled result");

  // a held result stays valid
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q) else $error("stalled result dropped");

  // a zero B4 forces zero pressure and flags the error
  a_b4_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && b4z_q |-> press_q == '0 && err_q) else $error("B4 zero not handled");

  // a held pipeline does not move the divider valid outputs
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v12i) && $stable(v4i)) else $error("divider moved while held");
`endif

endmodule
